### rtl/raster_fill_engine_top_macros.svh
// Assertion macros used by the fill engine datapath.
`ifndef RASTER_FILL_ENGINE_TOP_MACROS_SVH
`define RASTER_FILL_ENGINE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RFE_ASSERT_NOW(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RFE_ASSERT_NEXT(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) else $error(msg);

`endif

### rtl/rfe_pkg.sv
// Shared types and constants of the raster fill engine.
`default_nettype none
package rfe_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   localparam int OP_W      = 3;
   localparam int CRD_W     = 12;
   localparam int SIZE_W    = 11;
   localparam int COLOR_W   = 32;
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int SC_W      = 14;               // signed shape coordinate
   localparam int CH_W      = 8;
   localparam int NUM_CH    = 4;
   localparam int NUM_W     = CH_W + SIZE_W;    // gradient numerator
   localparam int SQ_W      = 2 * SIZE_W;
   localparam int PROD_W    = 2 * SQ_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam logic [CSR_W-1:0] SURFACE_RESET = CSR_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR    = 3'd0,
      OP_RECT     = 3'd1,
      OP_ROUND    = 3'd2,
      OP_ELLIPSE  = 3'd3,
      OP_STROKE   = 3'd4,
      OP_GRADIENT = 3'd5,
      OP_READ     = 3'd6
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SURFACE_WIDTH  = 1'b0,
      CSR_SURFACE_HEIGHT = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      BAR_TOP, BAR_BOTTOM, BAR_LEFT, BAR_RIGHT
   } bar_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CLEAR, S_SETUP, S_CLIP, S_PRE1, S_PRE2,
      S_ROW_A, S_ROW_B, S_DIV, S_PIX_A, S_PIX_B, S_PIX_W, S_READ, S_RDLOAD
   } state_type;

   typedef struct packed {
      op_type  op;
      bar_type bar;
      logic    capture;
      logic    clr_start;
      logic    clr_step;
      logic    clr_zero;
      logic    box_load;
      logic    clip_load;
      logic    pre1;
      logic    pre2;
      logic    row_a;
      logic    row_b;
      logic    div_start;
      logic    pix_a;
      logic    pix_b;
      logic    pix_w;
      logic    rd_issue;
      logic    rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic box_empty;
      logic last_col;
      logic last_row;
      logic div_busy;
      logic rsp_busy;
   } status_type;

endpackage
`default_nettype wire

### rtl/rfe_div.sv
// Bit-serial restoring divider for one gradient channel.
`default_nettype none
module rfe_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [rfe_pkg::NUM_W-1:0]  num,
   input  wire logic [rfe_pkg::SIZE_W-1:0] den,
   output logic      [rfe_pkg::CH_W-1:0]   quo,
   output logic                           busy
);
   import rfe_pkg::*;

   logic [NUM_W-1:0]     acc_ff, acc_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SIZE_W:0]      rem_sh;
   logic                 ge;

   always_comb begin
      rem_sh = {rem_ff, acc_ff[NUM_W-1]};
      ge     = rem_sh >= {1'b0, den};
      acc_in = acc_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         acc_in = num;
         rem_in = '0;
         cnt_in = DIV_CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         acc_in = {acc_ff[NUM_W-2:0], ge};
         rem_in = ge ? SIZE_W'(rem_sh - {1'b0, den}) : SIZE_W'(rem_sh);
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   // quotient never exceeds the channel difference, so it fits one channel
   assign quo  = acc_ff[CH_W-1:0];
   assign busy = cnt_ff != '0;

endmodule
`default_nettype wire

### rtl/rfe_ctrl.sv
// Command sequencer of the raster fill engine.
`default_nettype none
module rfe_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [rfe_pkg::OP_W-1:0] req_operation,
   input  wire rfe_pkg::status_type      status,
   output rfe_pkg::cmd_type             cmd
);
   import rfe_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   bar_type   bar_ff, bar_in;
   logic      shaped;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         op_ff    <= OP_CLEAR;
         bar_ff   <= BAR_TOP;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         bar_ff   <= bar_in;
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.op    = op_ff;
      cmd.bar   = bar_ff;
      state_in  = state_ff;
      op_in     = op_ff;
      bar_in    = bar_ff;
      req_ready = 1'b0;
      shaped    = (op_ff == OP_ROUND) || (op_ff == OP_ELLIPSE);
      case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            cmd.clr_zero = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.clr_start = 1'b1;
               op_in         = op_type'(req_operation);
               bar_in        = BAR_TOP;
               case (req_operation) inside
                  OP_CLEAR:                 state_in = S_CLEAR;
                  [OP_RECT:OP_GRADIENT]:    state_in = S_SETUP;
                  OP_READ:                  state_in = S_READ;
                  default:                  state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_SETUP: begin
            cmd.box_load = 1'b1;
            state_in     = S_CLIP;
         end
         S_CLIP: begin
            cmd.clip_load = 1'b1;
            if (status.box_empty) begin
               if (op_ff == OP_STROKE && bar_ff != BAR_RIGHT) begin
                  bar_in   = bar_type'(bar_ff + 2'd1);
                  state_in = S_SETUP;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = shaped ? S_PRE1 : S_ROW_A;
            end
         end
         S_PRE1: begin
            cmd.pre1 = 1'b1;
            state_in = S_PRE2;
         end
         S_PRE2: begin
            cmd.pre2 = 1'b1;
            state_in = S_ROW_A;
         end
         S_ROW_A: begin
            cmd.row_a = 1'b1;
            state_in  = S_ROW_B;
         end
         S_ROW_B: begin
            cmd.row_b = 1'b1;
            if (op_ff == OP_GRADIENT) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = shaped ? S_PIX_A : S_PIX_W;
            end
         end
         S_DIV: begin
            if (!status.div_busy) state_in = S_PIX_W;
         end
         S_PIX_A: begin
            cmd.pix_a = 1'b1;
            state_in  = (op_ff == OP_ELLIPSE) ? S_PIX_B : S_PIX_W;
         end
         S_PIX_B: begin
            cmd.pix_b = 1'b1;
            state_in  = S_PIX_W;
         end
         S_PIX_W: begin
            cmd.pix_w = 1'b1;
            if (status.last_col && status.last_row) begin
               if (op_ff == OP_STROKE && bar_ff != BAR_RIGHT) begin
                  bar_in   = bar_type'(bar_ff + 2'd1);
                  state_in = S_SETUP;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (status.last_col) begin
               state_in = S_ROW_A;
            end else begin
               state_in = shaped ? S_PIX_A : S_PIX_W;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RDLOAD;
         end
         S_RDLOAD: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### rtl/rfe_dp.sv
// Datapath of the raster fill engine: clipping, shape tests, store, read-back.
`default_nettype none
`include "raster_fill_engine_top_macros.svh"
module rfe_dp #(
   parameter int MAX_WIDTH  = rfe_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rfe_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire rfe_pkg::cmd_type                  cmd,
   output rfe_pkg::status_type                   status,
   input  wire logic signed [rfe_pkg::CRD_W-1:0]  req_pos_x,
   input  wire logic signed [rfe_pkg::CRD_W-1:0]  req_pos_y,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_size_w,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_size_h,
   input  wire logic [rfe_pkg::COLOR_W-1:0]       req_fill_color,
   input  wire logic [rfe_pkg::COLOR_W-1:0]       req_second_color,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_corner_radius,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_stroke_thickness,
   input  wire logic                             csr_write_enable,
   input  wire logic [rfe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rfe_pkg::CSR_W-1:0]         csr_write_data,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output logic [rfe_pkg::COLOR_W-1:0]            rsp_read_color,
   output logic                                  rsp_read_error
);
   import rfe_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW     = $clog2(MAX_WIDTH + 1);
   localparam int YW     = $clog2(MAX_HEIGHT + 1);
   localparam int CXW    = (XW > CSR_W) ? XW : CSR_W;
   localparam int CYW    = (YW > CSR_W) ? YW : CSR_W;
   localparam int LW     = XW + YW;

   // captured command fields
   logic signed [CRD_W-1:0] x_ff, y_ff;
   logic [SIZE_W-1:0]       w_ff, h_ff, rad_req_ff, th_ff;
   logic [COLOR_W-1:0]      c1_ff, c2_ff;

   logic [CSR_W-1:0]        csr_w_ff, csr_h_ff;
   logic [XW-1:0]           sw;
   logic [YW-1:0]           sh;
   logic signed [SC_W-1:0]  sw_s, sh_s, x_s, y_s, w_s, h_s, th_s;

   // box and clip
   logic signed [SC_W-1:0]  box_x_in, box_y_in, box_x_ff, box_y_ff;
   logic [SIZE_W-1:0]       box_w_in, box_h_in, box_w_ff, box_h_ff;
   logic signed [SC_W-1:0]  c_l, c_t, c_r, c_b, rgt, bot;
   logic [XW-1:0]           l_ff, r_ff, px_ff;
   logic [YW-1:0]           t_ff, b_ff, py_ff;
   logic [XW:0]             px_nx;
   logic [YW:0]             py_nx;

   // shape arithmetic
   logic [SIZE_W-1:0]       lx, ly, half, rowm, colm;
   logic signed [SC_W-1:0]  lx_full, ly_full;
   logic [SIZE_W-1:0]       rad_ff, steps_ff;
   logic [SQ_W-1:0]         w2_ff, h2_ff, rad2_ff, rowsq_ff, pa_ff;
   logic [PROD_W-1:0]       wh2_ff, ty_ff, tx_ff;
   logic [LW-1:0]           row_lin, rd_lin;
   logic [ADDR_W-1:0]       row_base_ff, pix_addr;
   logic                    covered;

   // gradient
   logic [NUM_W-1:0]        prod_ff [NUM_CH];
   logic                    neg_ff  [NUM_CH];
   logic [CH_W-1:0]         quo     [NUM_CH];
   logic                    busy    [NUM_CH];
   logic [COLOR_W-1:0]      grad_color;

   // store
   logic [COLOR_W-1:0]      frame_store [DEPTH];
   logic [ADDR_W-1:0]       clr_addr_ff, wa, ra;
   logic                    we;
   logic [COLOR_W-1:0]      wd, rd_ff;
   logic                    rd_err, rd_err_ff;
   logic                    rsp_valid_ff;
   logic [COLOR_W-1:0]      rsp_color_ff;
   logic                    rsp_error_ff;

   function automatic logic [SIZE_W-1:0] corner_off(input logic [SIZE_W-1:0] l,
                                                   input logic [SIZE_W-1:0] side,
                                                   input logic [SIZE_W-1:0] rad);
      logic [SIZE_W-1:0] inner;
      logic [SIZE_W-1:0] res;
      inner = side - rad;
      if (l < rad)
         res = rad - l;
      else if (l >= inner)
         res = l - inner + SIZE_W'(1);
      else
         res = '0;
      return res;
   endfunction

   // |2l + 1 - side|, centre offset of the ellipse in half pixels
   function automatic logic [SIZE_W-1:0] ell_term(input logic [SIZE_W-1:0] l,
                                                 input logic [SIZE_W-1:0] side);
      logic signed [SIZE_W+1:0] e;
      logic signed [SIZE_W+1:0] m;
      e = $signed({1'b0, l, 1'b1}) - $signed({2'b00, side});
      m = (e < 0) ? -e : e;
      return m[SIZE_W-1:0];
   endfunction

   // ---- surface size, saturated to the store ----
   always_comb begin
      sw   = (CXW'(csr_w_ff) > CXW'(MAX_WIDTH))  ? XW'(MAX_WIDTH)  : XW'(csr_w_ff);
      sh   = (CYW'(csr_h_ff) > CYW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(csr_h_ff);
      sw_s = SC_W'($signed({1'b0, sw}));
      sh_s = SC_W'($signed({1'b0, sh}));
      x_s  = SC_W'(x_ff);
      y_s  = SC_W'(y_ff);
      w_s  = SC_W'($signed({1'b0, w_ff}));
      h_s  = SC_W'($signed({1'b0, h_ff}));
      th_s = SC_W'($signed({1'b0, th_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_w_ff <= SURFACE_RESET;
         csr_h_ff <= SURFACE_RESET;
      end else if (csr_write_enable) begin
         case (csr_type'(csr_index))
            CSR_SURFACE_WIDTH:  csr_w_ff <= csr_write_data;
            CSR_SURFACE_HEIGHT: csr_h_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---- box selection (stroke bars) and clip ----
   always_comb begin
      box_x_in = x_s;
      box_y_in = y_s;
      box_w_in = w_ff;
      box_h_in = h_ff;
      if (cmd.op == OP_STROKE) begin
         case (cmd.bar)
            BAR_TOP:    box_h_in = th_ff;
            BAR_BOTTOM: begin
               box_y_in = y_s + h_s - th_s;
               box_h_in = th_ff;
            end
            BAR_LEFT:   box_w_in = th_ff;
            BAR_RIGHT:  begin
               box_x_in = x_s + w_s - th_s;
               box_w_in = th_ff;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rgt = box_x_ff + SC_W'($signed({1'b0, box_w_ff}));
      bot = box_y_ff + SC_W'($signed({1'b0, box_h_ff}));
      c_l = (box_x_ff > 0) ? box_x_ff : '0;
      c_t = (box_y_ff > 0) ? box_y_ff : '0;
      c_r = (rgt < sw_s) ? rgt : sw_s;
      c_b = (bot < sh_s) ? bot : sh_s;
   end

   // ---- local coordinates and per-row / per-pixel terms ----
   always_comb begin
      lx_full = SC_W'($signed({1'b0, px_ff})) - x_s;
      ly_full = SC_W'($signed({1'b0, py_ff})) - y_s;
      lx      = lx_full[SIZE_W-1:0];
      ly      = ly_full[SIZE_W-1:0];
      half    = ((w_ff < h_ff) ? w_ff : h_ff) >> 1;
      rowm    = (cmd.op == OP_ELLIPSE) ? ell_term(ly, h_ff) : corner_off(ly, h_ff, rad_ff);
      colm    = (cmd.op == OP_ELLIPSE) ? ell_term(lx, w_ff) : corner_off(lx, w_ff, rad_ff);
      row_lin = LW'(py_ff) * LW'(sw);
      px_nx   = {1'b0, px_ff} + 1'b1;
      py_nx   = {1'b0, py_ff} + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff       <= req_pos_x;
         y_ff       <= req_pos_y;
         w_ff       <= req_size_w;
         h_ff       <= req_size_h;
         c1_ff      <= req_fill_color;
         c2_ff      <= req_second_color;
         rad_req_ff <= req_corner_radius;
         th_ff      <= req_stroke_thickness;
      end
      if (cmd.box_load) begin
         box_x_ff <= box_x_in;
         box_y_ff <= box_y_in;
         box_w_ff <= box_w_in;
         box_h_ff <= box_h_in;
      end
      if (cmd.clip_load) begin
         l_ff  <= c_l[XW-1:0];
         r_ff  <= c_r[XW-1:0];
         t_ff  <= c_t[YW-1:0];
         b_ff  <= c_b[YW-1:0];
         px_ff <= c_l[XW-1:0];
         py_ff <= c_t[YW-1:0];
      end
      if (cmd.pre1) begin
         rad_ff <= (rad_req_ff < half) ? rad_req_ff : half;
         w2_ff  <= SQ_W'(w_ff) * SQ_W'(w_ff);
         h2_ff  <= SQ_W'(h_ff) * SQ_W'(h_ff);
      end
      if (cmd.pre2) begin
         wh2_ff  <= PROD_W'(w2_ff) * PROD_W'(h2_ff);
         rad2_ff <= SQ_W'(rad_ff) * SQ_W'(rad_ff);
      end
      if (cmd.row_a) begin
         row_base_ff <= row_lin[ADDR_W-1:0];
         rowsq_ff    <= SQ_W'(rowm) * SQ_W'(rowm);
         steps_ff    <= (h_ff > SIZE_W'(2)) ? h_ff - SIZE_W'(1) : SIZE_W'(1);
         for (int ch = 0; ch < NUM_CH; ch++) begin
            neg_ff[ch]  <= c2_ff[CH_W*ch +: CH_W] < c1_ff[CH_W*ch +: CH_W];
            prod_ff[ch] <= NUM_W'((c2_ff[CH_W*ch +: CH_W] < c1_ff[CH_W*ch +: CH_W])
                              ? c1_ff[CH_W*ch +: CH_W] - c2_ff[CH_W*ch +: CH_W]
                              : c2_ff[CH_W*ch +: CH_W] - c1_ff[CH_W*ch +: CH_W])
                           * NUM_W'(ly);
         end
      end
      if (cmd.row_b) begin
         ty_ff <= PROD_W'(rowsq_ff) * PROD_W'(w2_ff);
      end
      if (cmd.pix_a) begin
         pa_ff <= SQ_W'(colm) * SQ_W'(colm);
      end
      if (cmd.pix_b) begin
         tx_ff <= PROD_W'(pa_ff) * PROD_W'(h2_ff);
      end
      if (cmd.pix_w) begin
         if (px_nx == {1'b0, r_ff}) begin
            px_ff <= l_ff;
            py_ff <= py_nx[YW-1:0];
         end else begin
            px_ff <= px_nx[XW-1:0];
         end
      end
   end

   // ---- gradient channels ----
   for (genvar g = 0; g < NUM_CH; g++) begin : g_div
      rfe_div u_div (
         .clock (clock),
         .reset (reset),
         .start (cmd.div_start),
         .num   (prod_ff[g]),
         .den   (steps_ff),
         .quo   (quo[g]),
         .busy  (busy[g])
      );
   end

   always_comb begin
      logic signed [CH_W+1:0] v;
      grad_color = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         v = $signed({2'b00, c1_ff[CH_W*ch +: CH_W]})
             + (neg_ff[ch] ? -$signed({2'b00, quo[ch]}) : $signed({2'b00, quo[ch]}));
         if (v < 0)
            grad_color[CH_W*ch +: CH_W] = '0;
         else if (v > $signed((CH_W+2)'(255)))
            grad_color[CH_W*ch +: CH_W] = '1;
         else
            grad_color[CH_W*ch +: CH_W] = v[CH_W-1:0];
      end
   end

   // ---- coverage test ----
   always_comb begin
      case (cmd.op)
         OP_ELLIPSE:
            covered = ((PROD_W+1)'(tx_ff) + (PROD_W+1)'(ty_ff)) <= (PROD_W+1)'(wh2_ff);
         OP_ROUND:
            covered = (pa_ff == '0) || (rowsq_ff == '0) ||
                      (((SQ_W+1)'(pa_ff) + (SQ_W+1)'(rowsq_ff)) <= (SQ_W+1)'(rad2_ff));
         default:
            covered = 1'b1;
      endcase
   end

   // ---- store ports ----
   always_comb begin
      pix_addr = row_base_ff + ADDR_W'(px_ff);
      we       = cmd.clr_step || (cmd.pix_w && covered);
      wa       = cmd.clr_step ? clr_addr_ff : pix_addr;
      if (cmd.clr_step)
         wd = cmd.clr_zero ? '0 : c1_ff;
      else
         wd = (cmd.op == OP_GRADIENT) ? grad_color : c1_ff;
      rd_lin = LW'(y_ff[YW-1:0]) * LW'(sw) + LW'(x_ff[XW-1:0]);
      ra     = rd_lin[ADDR_W-1:0];
      rd_err = (x_ff < 0) || (y_ff < 0) || (x_s >= sw_s) || (y_s >= sh_s);
   end

   always_ff @(posedge clock) begin
      if (we) frame_store[wa] <= wd;
      if (cmd.rd_issue) rd_ff <= frame_store[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_start) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) rd_err_ff <= rd_err;
      if (cmd.rsp_load) begin
         rsp_color_ff <= rd_err_ff ? '0 : rd_ff;
         rsp_error_ff <= rd_err_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_color = rsp_color_ff;
   assign rsp_read_error = rsp_error_ff;

   always_comb begin
      status           = '0;
      status.clr_last  = clr_addr_ff == ADDR_W'(DEPTH - 1);
      status.box_empty = !((c_l < c_r) && (c_t < c_b));
      status.last_col  = px_nx == {1'b0, r_ff};
      status.last_row  = py_nx == {1'b0, b_ff};
      for (int ch = 0; ch < NUM_CH; ch++)
         status.div_busy = status.div_busy | busy[ch];
      status.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   `RFE_ASSERT_NOW(a_pix_in_clip, cmd.pix_w, (px_ff >= l_ff) && (px_ff < r_ff) && (py_ff >= t_ff) && (py_ff < b_ff), "pixel walk left its clip box")
   `RFE_ASSERT_NOW(a_pix_in_surface, cmd.pix_w, (px_ff < sw) && (py_ff < sh), "pixel write outside the surface")
   `RFE_ASSERT_NOW(a_rsp_slot_free, cmd.rsp_load, !(rsp_valid_ff && !rsp_ready), "result overwritten before it was taken")
   `RFE_ASSERT_NEXT(a_div_runs, cmd.div_start, status.div_busy, "gradient divider failed to start")

endmodule
`default_nettype wire

### rtl/raster_fill_engine_top.sv
// Top level of the raster fill engine: sequencer plus datapath.
`default_nettype none
// Raster fill engine. Draws clipped shapes into an on-chip frame store of
// MAX_WIDTH*MAX_HEIGHT packed RGBA words and answers pixel reads. After reset
// the store is swept to zero, one word a cycle, and req_ready stays low until
// the sweep ends; csr writes are taken during the sweep. One command is in
// flight at a time; the store has a single write port and every covered pixel
// costs one write, so the pixel walk sets the command time. A stroke walks four
// boxes; rounded rectangles and ellipses add the S_PRE1 and S_PRE2 states, and
// S_PIX_A (ellipse also S_PIX_B) before each S_PIX_W; a gradient runs the
// bit-serial channel dividers on every row; a read waits while the previous
// result beat is still waiting. A shape clipped away entirely, or operation
// code seven, returns to idle and produces no result beat. Only a read yields
// a result beat.
module raster_fill_engine_top #(
   parameter int MAX_WIDTH  = rfe_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rfe_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [rfe_pkg::OP_W-1:0]          req_operation,
   input  wire logic signed [rfe_pkg::CRD_W-1:0]  req_pos_x,
   input  wire logic signed [rfe_pkg::CRD_W-1:0]  req_pos_y,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_size_w,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_size_h,
   input  wire logic [rfe_pkg::COLOR_W-1:0]       req_fill_color,
   input  wire logic [rfe_pkg::COLOR_W-1:0]       req_second_color,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_corner_radius,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_stroke_thickness,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [rfe_pkg::COLOR_W-1:0]            rsp_read_color,
   output logic                                  rsp_read_error,
   input  wire logic                             csr_write_enable,
   input  wire logic [rfe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rfe_pkg::CSR_W-1:0]         csr_write_data
);
   import rfe_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: clearing sweep, box/bar walk, row and pixel phases
   rfe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath: clipping, shape tests, gradient dividers, store, result beat
   rfe_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_size_w           (req_size_w),
      .req_size_h           (req_size_h),
      .req_fill_color       (req_fill_color),
      .req_second_color     (req_second_color),
      .req_corner_radius    (req_corner_radius),
      .req_stroke_thickness (req_stroke_thickness),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_read_color       (rsp_read_color),
      .rsp_read_error       (rsp_read_error)
   );

endmodule
`default_nettype wire

### test/raster_fill_engine_checker.sv
// Checker for the raster fill engine: frame store predictor and read-back comparison.
`timescale 1ns / 100ps
module raster_fill_engine_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [rfe_pkg::OP_W-1:0]          req_operation,
   input  wire logic signed [rfe_pkg::CRD_W-1:0]  req_pos_x,
   input  wire logic signed [rfe_pkg::CRD_W-1:0]  req_pos_y,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_size_w,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_size_h,
   input  wire logic [rfe_pkg::COLOR_W-1:0]       req_fill_color,
   input  wire logic [rfe_pkg::COLOR_W-1:0]       req_second_color,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_corner_radius,
   input  wire logic [rfe_pkg::SIZE_W-1:0]        req_stroke_thickness,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [rfe_pkg::COLOR_W-1:0]       rsp_read_color,
   input  wire logic                              rsp_read_error,
   input  wire logic                              csr_write_enable,
   input  wire logic [rfe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rfe_pkg::CSR_W-1:0]         csr_write_data,
   output int                                     failures,
   output int                                     pending
);
   import rfe_pkg::*;

   localparam int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

   typedef struct {
      logic [COLOR_W-1:0] color;
      logic               error;
   } pixel_read_type;

   logic [COLOR_W-1:0] pixels [DEPTH];
   logic [CSR_W-1:0]   surf_w, surf_h;
   pixel_read_type     read_q [$];
   int                 rsp_seen;

   function automatic int act_w();
      return (surf_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(surf_w);
   endfunction

   function automatic int act_h();
      return (surf_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(surf_h);
   endfunction

   function automatic void plot(int x, int y, logic [COLOR_W-1:0] c);
      int a;
      a = y * act_w() + x;
      if (a >= 0 && a < DEPTH) pixels[a] = c;
   endfunction

   function automatic bit clip(int x, int y, int w, int h,
                               output int l, output int t, output int r, output int b);
      l = (x > 0) ? x : 0;
      t = (y > 0) ? y : 0;
      r = (x + w < act_w()) ? x + w : act_w();
      b = (y + h < act_h()) ? y + h : act_h();
      return (l < r) && (t < b);
   endfunction

   function automatic void paint_box(int x, int y, int w, int h, logic [COLOR_W-1:0] c);
      int l, t, r, b;
      if (!clip(x, y, w, h, l, t, r, b)) return;
      for (int py = t; py < b; py++)
         for (int px = l; px < r; px++) plot(px, py, c);
   endfunction

   function automatic void paint_round(int x, int y, int w, int h, logic [COLOR_W-1:0] c,
                                       int rq);
      int l, t, r, b, rad, lim, lx, ly, dx, dy;
      if (!clip(x, y, w, h, l, t, r, b)) return;
      lim = ((w < h) ? w : h) / 2;
      rad = (rq < lim) ? rq : lim;
      for (int py = t; py < b; py++) begin
         for (int px = l; px < r; px++) begin
            lx = px - x;
            ly = py - y;
            dx = 0;
            dy = 0;
            if (lx < rad) dx = rad - lx;
            else if (lx >= w - rad) dx = lx - (w - rad - 1);
            if (ly < rad) dy = rad - ly;
            else if (ly >= h - rad) dy = ly - (h - rad - 1);
            if (dx == 0 || dy == 0 || dx * dx + dy * dy <= rad * rad) plot(px, py, c);
         end
      end
   endfunction

   function automatic void paint_ellipse(int x, int y, int w, int h, logic [COLOR_W-1:0] c);
      int l, t, r, b;
      longint w2, h2, ty, tx, ey, ex;
      if (w <= 0 || h <= 0) return;
      if (!clip(x, y, w, h, l, t, r, b)) return;
      w2 = longint'(w) * w;
      h2 = longint'(h) * h;
      for (int py = t; py < b; py++) begin
         ey = 2 * longint'(py) + 1 - 2 * longint'(y) - h;
         ty = ey * ey * w2;
         for (int px = l; px < r; px++) begin
            ex = 2 * longint'(px) + 1 - 2 * longint'(x) - w;
            tx = ex * ex * h2;
            if (tx + ty <= w2 * h2) plot(px, py, c);
         end
      end
   endfunction

   function automatic logic [COLOR_W-1:0] shade(logic [COLOR_W-1:0] top,
                                                logic [COLOR_W-1:0] bot, int step, int steps);
      logic [COLOR_W-1:0] o;
      int a, z, v;
      o = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         a = int'(top[ch*CH_W +: CH_W]);
         z = int'(bot[ch*CH_W +: CH_W]);
         v = a + ((z - a) * step) / steps;   // truncates toward zero
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         o[ch*CH_W +: CH_W] = v[CH_W-1:0];
      end
      return o;
   endfunction

   function automatic void paint_gradient(int x, int y, int w, int h,
                                          logic [COLOR_W-1:0] c1, logic [COLOR_W-1:0] c2);
      int l, t, r, b, steps;
      logic [COLOR_W-1:0] c;
      steps = (h - 1 > 1) ? h - 1 : 1;
      if (!clip(x, y, w, h, l, t, r, b)) return;
      for (int py = t; py < b; py++) begin
         c = shade(c1, c2, py - y, steps);
         for (int px = l; px < r; px++) plot(px, py, c);
      end
   endfunction

   task automatic flag_mismatch(string what, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] want);
      $display("mismatch on %s at beat %0d: got %h, expected %h", what, rsp_seen, got, want);
      failures++;
   endtask

   initial begin
      failures = 0;
      pending  = 0;
      rsp_seen = 0;
   end

   always @(posedge clock) begin
      int x, y, w, h, th;
      pixel_read_type e;
      if (reset) begin
         surf_w = SURFACE_RESET;
         surf_h = SURFACE_RESET;
         for (int i = 0; i < DEPTH; i++) pixels[i] = '0;
         read_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_type'(csr_index))
               CSR_SURFACE_WIDTH:  surf_w = csr_write_data;
               CSR_SURFACE_HEIGHT: surf_h = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (read_q.size() == 0) begin
               $display("unexpected result beat %0d: colour %h error %b",
                        rsp_seen, rsp_read_color, rsp_read_error);
               failures++;
            end else begin
               e = read_q.pop_front();
               if (rsp_read_color !== e.color) flag_mismatch("read_color", rsp_read_color, e.color);
               if (rsp_read_error !== e.error)
                  flag_mismatch("read_error", {31'd0, rsp_read_error}, {31'd0, e.error});
            end
            rsp_seen++;
         end
         if (req_valid && req_ready) begin
            x  = int'(req_pos_x);
            y  = int'(req_pos_y);
            w  = int'(req_size_w);
            h  = int'(req_size_h);
            th = int'(req_stroke_thickness);
            case (req_operation)
               OP_CLEAR:    for (int i = 0; i < DEPTH; i++) pixels[i] = req_fill_color;
               OP_RECT:     paint_box(x, y, w, h, req_fill_color);
               OP_ROUND:    paint_round(x, y, w, h, req_fill_color, int'(req_corner_radius));
               OP_ELLIPSE:  paint_ellipse(x, y, w, h, req_fill_color);
               OP_STROKE: begin
                  paint_box(x, y, w, th, req_fill_color);
                  paint_box(x, y + h - th, w, th, req_fill_color);
                  paint_box(x, y, th, h, req_fill_color);
                  paint_box(x + w - th, y, th, h, req_fill_color);
               end
               OP_GRADIENT: paint_gradient(x, y, w, h, req_fill_color, req_second_color);
               OP_READ: begin
                  if (x < 0 || y < 0 || x >= act_w() || y >= act_h()) begin
                     e.color = '0;
                     e.error = 1'b1;
                  end else begin
                     e.color = pixels[y * act_w() + x];
                     e.error = 1'b0;
                  end
                  read_q.push_back(e);
               end
               default: ;   // code seven does nothing
            endcase
         end
      end
      pending = read_q.size();
   end

endmodule

### test/testbench.sv
// Top of the raster fill engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
   import rfe_pkg::*;

   // Longest legal silence: a stroke whose four bars each cover the whole
   // surface; the limit leaves room for any single command plus the receiver
   // hold-off.
   localparam int QUIET_LIMIT = 80000;
   localparam int SETTLE      = 18000;   // worst command time, before csr writes
   localparam int HOLD_CYCLES = 400;
   localparam int RAND_ITEMS  = 120;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_W-1:0]          req_operation = '0;
   logic signed [CRD_W-1:0]  req_pos_x = '0;
   logic signed [CRD_W-1:0]  req_pos_y = '0;
   logic [SIZE_W-1:0]        req_size_w = '0;
   logic [SIZE_W-1:0]        req_size_h = '0;
   logic [COLOR_W-1:0]       req_fill_color = '0;
   logic [COLOR_W-1:0]       req_second_color = '0;
   logic [SIZE_W-1:0]        req_corner_radius = '0;
   logic [SIZE_W-1:0]        req_stroke_thickness = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COLOR_W-1:0]       rsp_read_color;
   logic                     rsp_read_error;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_W-1:0]         csr_write_data = '0;

   int   failures, pending;
   logic req_beat = 1'b0;    // a request beat was taken at the last rising edge
   bit   steady = 1'b0;      // no random gaps are started on either side while set
   bit   hold_go = 1'b0;
   bit   hold_done = 1'b0;
   int   quiet_cycles = 0;

   always #5 clock = ~clock;

   raster_fill_engine_top dut (.*);

   raster_fill_engine_checker checker_i (.*);

   always @(posedge clock) req_beat <= req_valid && req_ready;

   // Watchdog: counts cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("** raster_fill_engine_top: FAILED **");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(20, 70);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int gap_left;
      gap_left = 0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) gap_left = gap_len();
         end
      end
   end

   // Offers one request beat and returns at the falling edge after it is taken.
   // Valid stays high so a back-to-back beat can follow.
   task automatic send(op_type op, int x, int y, int w, int h, logic [31:0] c1,
                       logic [31:0] c2, int rad, int th);
      req_operation        <= op;
      req_pos_x            <= CRD_W'(x);
      req_pos_y            <= CRD_W'(y);
      req_size_w           <= SIZE_W'(w);
      req_size_h           <= SIZE_W'(h);
      req_fill_color       <= c1;
      req_second_color     <= c2;
      req_corner_radius    <= SIZE_W'(rad);
      req_stroke_thickness <= SIZE_W'(th);
      req_valid            <= 1'b1;
      @(negedge clock);
      while (!req_beat) @(negedge clock);
   endtask

   task automatic sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return;
      req_valid <= 1'b0;
      repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 80)) @(negedge clock);
   endtask

   // Stop offering, wait for every read beat, then let any draw finish.
   task automatic drain(int extra);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic set_surface(int w, int h);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SURFACE_WIDTH;
      csr_write_data   <= CSR_W'(w);
      @(negedge clock);
      csr_index        <= CSR_SURFACE_HEIGHT;
      csr_write_data   <= CSR_W'(h);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int pick_coord();
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 4095)) - 2048;
      return $urandom_range(0, 80) - 10;
   endfunction

   function automatic int pick_size();
      if ($urandom_range(0, 12) == 0) return $urandom_range(0, 2047);
      return $urandom_range(0, 24);
   endfunction

   task automatic random_beat();
      int r;
      op_type op;
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_READ;
      else if (r < 47) op = OP_RECT;
      else if (r < 58) op = OP_ROUND;
      else if (r < 69) op = OP_ELLIPSE;
      else if (r < 80) op = OP_STROKE;
      else if (r < 93) op = OP_GRADIENT;
      else if (r < 96) op = OP_CLEAR;
      else op = op_type'(3'd7);
      send(op, pick_coord(), pick_coord(), pick_size(), pick_size(), $urandom, $urandom,
           ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 12),
           ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 8));
      sender_gap();
   endtask

   initial begin
      int sw [6] = '{64, 1, 0, 127, 37, 64};
      int sh [6] = '{64, 1, 5, 100, 19, 64};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: default surface, extremes and the special cases.
      send(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);                    // swept to zero
      send(OP_CLEAR, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
      send(OP_READ, 63, 63, 0, 0, 0, 0, 0, 0);
      send(OP_RECT, -2048, -2048, 2047, 2047, 32'h1234_5678, 0, 0, 0);
      send(OP_ROUND, 3, 2, 20, 13, 32'hA5A5_5A5A, 0, 2047, 0);  // radius limited
      send(OP_READ, 3, 2, 0, 0, 0, 0, 0, 0);
      send(OP_ELLIPSE, 40, 40, 1, 1, 32'h0F0F_0F0F, 0, 0, 0);
      send(OP_ELLIPSE, 30, 5, 9, 6, 32'hC3C3_3C3C, 0, 0, 0);
      send(OP_ELLIPSE, 10, 10, 0, 7, 32'hDEAD_BEEF, 0, 0, 0);   // zero side
      send(OP_READ, 34, 8, 0, 0, 0, 0, 0, 0);
      send(OP_STROKE, 5, 30, 12, 10, 32'h8000_0001, 0, 0, 0);   // zero thickness
      send(OP_STROKE, 20, 30, 0, 10, 32'h7FFF_FFFE, 0, 0, 3);   // zero width
      send(OP_STROKE, 50, 50, 8, 8, 32'h00FF_FF00, 0, 0, 2047);
      send(OP_GRADIENT, 0, 0, 64, 1, 32'hFF00_FF00, 32'h00FF_00FF, 0, 0);
      send(OP_GRADIENT, 0, 20, 64, 30, 32'hFF80_1000, 32'h0010_80FF, 0, 0);
      send(OP_GRADIENT, 0, 0, 5, 0, 32'h1111_1111, 32'h2222_2222, 0, 0);
      send(OP_READ, 7, 35, 0, 0, 0, 0, 0, 0);
      send(OP_READ, -1, 0, 0, 0, 0, 0, 0, 0);
      send(OP_READ, 64, 0, 0, 0, 0, 0, 0, 0);
      send(OP_READ, 0, 2047, 0, 0, 0, 0, 0, 0);
      send(op_type'(3'd7), 0, 0, 10, 10, 32'h5555_5555, 0, 0, 0);
      send(OP_READ, 5, 5, 0, 0, 0, 0, 0, 0);

      // Pressure: sender pauses until all reads are back, then the receiver
      // holds off while reads keep coming so the input side backs up.
      drain(0);
      hold_go = 1'b1;
      steady  = 1'b1;
      while (!hold_done) send(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                              0, 0, 0, 0, 0, 0);
      steady = 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         drain(SETTLE);
         set_surface(sw[ph], sh[ph]);
         steady = (ph == 4);
         for (int n = 0; n < RAND_ITEMS / 6; n++) random_beat();
      end
      steady = 1'b0;

      drain(SETTLE);
      if (failures == 0)
         $display("** raster_fill_engine_top: PASSED **");
      else
         $display("** raster_fill_engine_top: FAILED **");
      $finish;
   end

endmodule
